/* design/kce_pkg.sv */
// kce_pkg: sizes, command and status types shared by the k-means engine
// no dependencies; every other design file refers to it by scoped names
`timescale 1ns / 1ps
`default_nettype none
package kce_pkg;

   localparam int DIM_MAX = 8;
   localparam int K_MAX   = 8;
   localparam int N_MAX   = 1024;

   localparam int DATA_W    = 32;
   localparam int DW        = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
   localparam int KW        = (K_MAX > 1) ? $clog2(K_MAX) : 1;
   localparam int DCW       = $clog2(DIM_MAX + 1);
   localparam int KCW       = $clog2(K_MAX + 1);
   localparam int NCW       = $clog2(N_MAX + 1);
   localparam int OBS_DEPTH = DIM_MAX * N_MAX;
   localparam int OAW       = $clog2(OBS_DEPTH);
   localparam int TOTW      = $clog2(OBS_DEPTH + 1);
   localparam int CAW       = KW + DW;
   localparam int CEN_DEPTH = 2 ** CAW;
   localparam int SUM_W     = DATA_W + $clog2(N_MAX);
   localparam int SQ_W      = 2 * DATA_W;
   localparam int DIST_W    = SQ_W + $clog2(DIM_MAX);

   // fixed field and register widths
   localparam int CLU_OUT_W = 3;
   localparam int CRD_OUT_W = 3;
   localparam int CFG_DIM_W = 4;
   localparam int CFG_K_W   = 4;
   localparam int CFG_N_W   = 11;
   localparam int CFG_IT_W  = 10;
   localparam int CSR_W     = 11;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_DIM  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_K    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_N    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ITER = 2'd3;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_CLEAR,
      OP_RD_DIST,
      OP_DIFF,
      OP_MUL,
      OP_ACC,
      OP_CMP,
      OP_RD_SUM,
      OP_WR_SUM,
      OP_CNT,
      OP_RD_UPD,
      OP_DIV,
      OP_WR_UPD,
      OP_RD_SEED,
      OP_WR_SEED,
      OP_RD_CEN,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type          op;
      logic [OAW-1:0]     obs_addr;
      logic [KW-1:0]      clu;
      logic [DW-1:0]      crd;
      logic               first;
      logic               zero;
      logic               conv;
      logic               last;
   } kce_cmd_type;

   typedef struct packed {
      logic div_done;
      logic out_busy;
      logic same;
   } kce_status_type;

endpackage
`default_nettype wire

/* design/kce_req_if.sv */
// kce_req_if: coordinate input channel, valid/ready with one coordinate word
// uses kce_pkg for the data width
`timescale 1ns / 1ps
`default_nettype none
interface kce_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [kce_pkg::DATA_W-1:0]   coordinate_value;

   modport source (output valid, output coordinate_value, input ready);
   modport sink (input valid, input coordinate_value, output ready);
endinterface
`default_nettype wire

/* design/kce_rsp_if.sv */
// kce_rsp_if: centroid result channel, valid/ready with one centroid word
// uses kce_pkg for the field widths
`timescale 1ns / 1ps
`default_nettype none
interface kce_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [kce_pkg::DATA_W-1:0]      centroid_value;
   logic [kce_pkg::CLU_OUT_W-1:0]          cluster_index;
   logic [kce_pkg::CRD_OUT_W-1:0]          coordinate_index;
   logic                                   converged;
   logic                                   last_of_run;

   modport source (output valid, output centroid_value, output cluster_index,
                   output coordinate_index, output converged, output last_of_run,
                   input ready);
   modport sink (input valid, input centroid_value, input cluster_index,
                 input coordinate_index, input converged, input last_of_run,
                 output ready);
endinterface
`default_nettype wire

/* design/kce_div.sv */
// kce_div: restoring divider, one quotient bit per cycle, unsigned operands
// depends on kce_pkg for the sum and count widths
`timescale 1ns / 1ps
`default_nettype none
module kce_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [kce_pkg::SUM_W-1:0]  dividend,
   input  wire logic [kce_pkg::NCW-1:0]    divisor,
   output logic                            done,
   output logic [kce_pkg::SUM_W-1:0]       quotient
);
   localparam int STEP_W = $clog2(kce_pkg::SUM_W + 1);

   logic [kce_pkg::SUM_W-1:0] quo_ff;
   logic [kce_pkg::NCW-1:0]   rem_ff;
   logic [kce_pkg::NCW-1:0]   dvs_ff;
   logic [STEP_W-1:0]         step_ff;
   logic                      busy_ff;
   logic                      done_ff;
   logic [kce_pkg::NCW:0]     trial;
   logic                      fits;

   assign trial = {rem_ff, quo_ff[kce_pkg::SUM_W-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(kce_pkg::SUM_W);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? kce_pkg::NCW'(trial - {1'b0, dvs_ff})
                        : kce_pkg::NCW'(trial);
         quo_ff <= {quo_ff[kce_pkg::SUM_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider finished without running");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !$past(start) |-> $past(busy_ff))
      else $error("divider busy without start");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff != '0)
      else $error("divider step count ran out while busy");
endmodule
`default_nettype wire

/* design/kce_datapath.sv */
// kce_datapath: observation, centroid and sum stores, distance and mean units
// depends on kce_pkg and kce_div; driven by the command word from kce_ctrl
`timescale 1ns / 1ps
`default_nettype none
module kce_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire kce_pkg::kce_cmd_type              cmd,
   input  wire logic signed [kce_pkg::DATA_W-1:0] load_value,
   output kce_pkg::kce_status_type                status,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_valid,
   output logic signed [kce_pkg::DATA_W-1:0]      rsp_centroid_value,
   output logic [kce_pkg::CLU_OUT_W-1:0]          rsp_cluster_index,
   output logic [kce_pkg::CRD_OUT_W-1:0]          rsp_coordinate_index,
   output logic                                   rsp_converged,
   output logic                                   rsp_last_of_run
);
   localparam int DATA_W = kce_pkg::DATA_W;
   localparam int SUM_W  = kce_pkg::SUM_W;

   logic signed [DATA_W-1:0] obs_mem [kce_pkg::OBS_DEPTH];
   logic signed [DATA_W-1:0] cen_mem [kce_pkg::CEN_DEPTH];
   logic signed [SUM_W-1:0]  sum_mem [kce_pkg::CEN_DEPTH];

   logic [kce_pkg::CEN_DEPTH-1:0]  sum_vld_ff;
   logic signed [DATA_W-1:0]       obs_rd_ff;
   logic signed [DATA_W-1:0]       cen_rd_ff;
   logic signed [SUM_W-1:0]        sum_rd_ff;
   logic                           sum_rv_ff;
   logic [kce_pkg::CAW-1:0]        sum_addr_ff;
   logic [DATA_W-1:0]              mag_ff;
   logic [kce_pkg::SQ_W-1:0]       sq_ff;
   logic [kce_pkg::DIST_W-1:0]     dist_ff;
   logic [kce_pkg::DIST_W-1:0]     best_ff;
   logic [kce_pkg::KW-1:0]         best_idx_ff;
   logic [kce_pkg::NCW-1:0]        cnt_ff [kce_pkg::K_MAX];
   logic                           neg_ff;
   logic                           czero_ff;
   logic                           same_ff;
   logic                           rsp_valid_ff;
   logic signed [DATA_W-1:0]       rsp_value_ff;
   logic [kce_pkg::CLU_OUT_W-1:0]  rsp_clu_ff;
   logic [kce_pkg::CRD_OUT_W-1:0]  rsp_crd_ff;
   logic                           rsp_conv_ff;
   logic                           rsp_last_ff;

   logic [kce_pkg::CAW-1:0]   cen_addr;
   logic [kce_pkg::CAW-1:0]   sum_rd_addr;
   logic signed [DATA_W:0]    diff;
   logic [DATA_W-1:0]         mag;
   logic signed [SUM_W-1:0]   sum_cur;
   logic signed [SUM_W-1:0]   sum_new;
   logic [SUM_W-1:0]          sum_mag;
   logic                      div_start;
   logic                      div_done;
   logic [SUM_W-1:0]          quotient;
   logic [DATA_W-1:0]         q_low;
   logic signed [DATA_W-1:0]  mean;

   assign cen_addr    = {cmd.clu, cmd.crd};
   assign sum_rd_addr = (cmd.op == kce_pkg::OP_RD_SUM) ? {best_idx_ff, cmd.crd} : cen_addr;

   assign diff = {obs_rd_ff[DATA_W-1], obs_rd_ff} - {cen_rd_ff[DATA_W-1], cen_rd_ff};
   assign mag  = diff[DATA_W] ? DATA_W'(-diff) : DATA_W'(diff);

   assign sum_cur = sum_rv_ff ? sum_rd_ff : '0;
   assign sum_new = sum_cur + SUM_W'(obs_rd_ff);
   assign sum_mag = sum_cur[SUM_W-1] ? SUM_W'(-sum_cur) : SUM_W'(sum_cur);

   assign div_start = (cmd.op == kce_pkg::OP_DIV);
   assign q_low     = quotient[DATA_W-1:0];
   assign mean      = czero_ff ? '0 : (neg_ff ? DATA_W'(-q_low) : DATA_W'(q_low));

   kce_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_mag),
      .divisor  (cnt_ff[cmd.clu]),
      .done     (div_done),
      .quotient (quotient)
   );

   // stores and payload registers
   always_ff @(posedge clock) begin
      if (cmd.op == kce_pkg::OP_LOAD) begin
         obs_mem[cmd.obs_addr] <= load_value;
      end
      if (cmd.op == kce_pkg::OP_RD_DIST || cmd.op == kce_pkg::OP_RD_SUM ||
          cmd.op == kce_pkg::OP_RD_SEED) begin
         obs_rd_ff <= obs_mem[cmd.obs_addr];
      end
      if (cmd.op == kce_pkg::OP_RD_DIST || cmd.op == kce_pkg::OP_RD_UPD ||
          cmd.op == kce_pkg::OP_RD_CEN) begin
         cen_rd_ff <= cen_mem[cen_addr];
      end
      if (cmd.op == kce_pkg::OP_WR_SEED) begin
         cen_mem[cen_addr] <= cmd.zero ? '0 : obs_rd_ff;
      end
      if (cmd.op == kce_pkg::OP_WR_UPD) begin
         cen_mem[sum_addr_ff] <= mean;
      end
      if (cmd.op == kce_pkg::OP_RD_SUM || cmd.op == kce_pkg::OP_RD_UPD) begin
         sum_rd_ff   <= sum_mem[sum_rd_addr];
         sum_rv_ff   <= sum_vld_ff[sum_rd_addr];
         sum_addr_ff <= sum_rd_addr;
      end
      if (cmd.op == kce_pkg::OP_WR_SUM) begin
         sum_mem[sum_addr_ff] <= sum_new;
      end
      if (cmd.op == kce_pkg::OP_DIFF) begin
         mag_ff <= mag;
      end
      if (cmd.op == kce_pkg::OP_MUL) begin
         sq_ff <= mag_ff * mag_ff;
      end
      if (cmd.op == kce_pkg::OP_DIV) begin
         neg_ff   <= sum_cur[SUM_W-1];
         czero_ff <= (cnt_ff[cmd.clu] == '0);
      end
      if (cmd.op == kce_pkg::OP_EMIT) begin
         rsp_value_ff <= cen_rd_ff;
         rsp_clu_ff   <= kce_pkg::CLU_OUT_W'(cmd.clu);
         rsp_crd_ff   <= kce_pkg::CRD_OUT_W'(cmd.crd);
         rsp_conv_ff  <= cmd.conv;
         rsp_last_ff  <= cmd.last;
      end
   end

   // distance accumulation and nearest-centroid search
   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff     <= '0;
         best_ff     <= '0;
         best_idx_ff <= '0;
      end else begin
         unique case (cmd.op)
            kce_pkg::OP_CLEAR: begin
               dist_ff <= '0;
            end
            kce_pkg::OP_ACC: begin
               dist_ff <= dist_ff + kce_pkg::DIST_W'(sq_ff);
            end
            kce_pkg::OP_CMP: begin
               // strict compare keeps the lower index on a tie
               if (cmd.first || dist_ff < best_ff) begin
                  best_ff     <= dist_ff;
                  best_idx_ff <= cmd.clu;
               end
               dist_ff <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   // per-pass control state: sum valid bits, member counts, change flag, output
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_vld_ff   <= '0;
         same_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < kce_pkg::K_MAX; c++) begin
            cnt_ff[c] <= '0;
         end
      end else begin
         if (cmd.op == kce_pkg::OP_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (cmd.op)
            kce_pkg::OP_CLEAR: begin
               sum_vld_ff <= '0;
               same_ff    <= 1'b1;
               for (int c = 0; c < kce_pkg::K_MAX; c++) begin
                  cnt_ff[c] <= '0;
               end
            end
            kce_pkg::OP_WR_SUM: begin
               sum_vld_ff[sum_addr_ff] <= 1'b1;
            end
            kce_pkg::OP_CNT: begin
               cnt_ff[best_idx_ff] <= cnt_ff[best_idx_ff] + 1'b1;
            end
            kce_pkg::OP_WR_UPD: begin
               if (mean != cen_rd_ff) begin
                  same_ff <= 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign status.div_done = div_done;
   assign status.out_busy = rsp_valid_ff && !rsp_ready;
   assign status.same     = same_ff;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_centroid_value   = rsp_value_ff;
   assign rsp_cluster_index    = rsp_clu_ff;
   assign rsp_coordinate_index = rsp_crd_ff;
   assign rsp_converged        = rsp_conv_ff;
   assign rsp_last_of_run      = rsp_last_ff;

   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.op == kce_pkg::OP_EMIT |=> rsp_valid_ff)
      else $error("emitted word not presented");
   a_count_after_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.op == kce_pkg::OP_CLEAR |=> sum_vld_ff == '0)
      else $error("sum valid bits not cleared at pass start");
   a_change_seen: assert property (@(posedge clock) disable iff (reset)
      cmd.op == kce_pkg::OP_WR_UPD && mean != cen_rd_ff |=> !same_ff)
      else $error("changed mean not recorded");
endmodule
`default_nettype wire

/* design/kce_ctrl.sv */
// kce_ctrl: configuration registers, load position and the pass sequencer
// depends on kce_pkg; issues one command word a cycle to kce_datapath
`timescale 1ns / 1ps
`default_nettype none
module kce_ctrl (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [kce_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [kce_pkg::CSR_W-1:0]         csr_wdata,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   output kce_pkg::kce_cmd_type                   cmd,
   input  wire kce_pkg::kce_status_type           status
);
   typedef enum logic [4:0] {
      ST_LOAD,
      ST_SEED_RD,
      ST_SEED_WR,
      ST_PASS,
      ST_D_RD,
      ST_D_DIFF,
      ST_D_MUL,
      ST_D_ACC,
      ST_D_CMP,
      ST_A_RD,
      ST_A_WR,
      ST_A_CNT,
      ST_U_RD,
      ST_U_DIV,
      ST_U_WAIT,
      ST_U_WR,
      ST_U_END,
      ST_E_RD,
      ST_E_OUT
   } state_type;

   state_type                       state_ff;
   logic [kce_pkg::CFG_DIM_W-1:0]   dim_cfg_ff;
   logic [kce_pkg::CFG_K_W-1:0]     k_cfg_ff;
   logic [kce_pkg::CFG_N_W-1:0]     n_cfg_ff;
   logic [kce_pkg::CFG_IT_W-1:0]    iter_cfg_ff;
   logic [kce_pkg::OAW-1:0]         lp_ff;
   logic [kce_pkg::OAW-1:0]         base_ff;
   logic [kce_pkg::NCW-1:0]         i_ff;
   logic [kce_pkg::KCW-1:0]         c_ff;
   logic [kce_pkg::DCW-1:0]         j_ff;
   logic [kce_pkg::CFG_IT_W-1:0]    iter_ff;
   logic                            conv_ff;

   logic [kce_pkg::DCW-1:0]  dim;
   logic [kce_pkg::KCW-1:0]  k;
   logic [kce_pkg::NCW-1:0]  n;
   logic [kce_pkg::TOTW-1:0] total;
   logic                     j_last;
   logic                     c_last;
   logic                     i_last;
   logic                     it_last;

   // out-of-range settings clamp to the supported range
   always_comb begin
      if (dim_cfg_ff == '0) dim = kce_pkg::DCW'(1);
      else if (int'(dim_cfg_ff) > kce_pkg::DIM_MAX) dim = kce_pkg::DCW'(kce_pkg::DIM_MAX);
      else dim = kce_pkg::DCW'(dim_cfg_ff);
      if (k_cfg_ff == '0) k = kce_pkg::KCW'(1);
      else if (int'(k_cfg_ff) > kce_pkg::K_MAX) k = kce_pkg::KCW'(kce_pkg::K_MAX);
      else k = kce_pkg::KCW'(k_cfg_ff);
      if (n_cfg_ff == '0) n = kce_pkg::NCW'(1);
      else if (int'(n_cfg_ff) > kce_pkg::N_MAX) n = kce_pkg::NCW'(kce_pkg::N_MAX);
      else n = kce_pkg::NCW'(n_cfg_ff);
   end

   assign total   = kce_pkg::TOTW'(kce_pkg::TOTW'(dim) * kce_pkg::TOTW'(n));
   assign j_last  = (j_ff + 1'b1 == dim);
   assign c_last  = (c_ff + 1'b1 == k);
   assign i_last  = (i_ff + 1'b1 == n);
   assign it_last = ({1'b0, iter_ff} + 1'b1 == {1'b0, iter_cfg_ff});

   assign req_ready = (state_ff == ST_LOAD);

   always_comb begin
      cmd          = '0;
      cmd.op       = kce_pkg::OP_NONE;
      cmd.obs_addr = kce_pkg::OAW'(base_ff + kce_pkg::OAW'(j_ff));
      cmd.clu      = kce_pkg::KW'(c_ff);
      cmd.crd      = kce_pkg::DW'(j_ff);
      cmd.first    = (c_ff == '0);
      cmd.zero     = (kce_pkg::NCW'(c_ff) >= n);
      cmd.conv     = conv_ff;
      cmd.last     = c_last && j_last;
      unique case (state_ff)
         ST_LOAD: begin
            cmd.obs_addr = lp_ff;
            if (req_valid) cmd.op = kce_pkg::OP_LOAD;
         end
         ST_SEED_RD: cmd.op = kce_pkg::OP_RD_SEED;
         ST_SEED_WR: cmd.op = kce_pkg::OP_WR_SEED;
         ST_PASS:    cmd.op = kce_pkg::OP_CLEAR;
         ST_D_RD:    cmd.op = kce_pkg::OP_RD_DIST;
         ST_D_DIFF:  cmd.op = kce_pkg::OP_DIFF;
         ST_D_MUL:   cmd.op = kce_pkg::OP_MUL;
         ST_D_ACC:   cmd.op = kce_pkg::OP_ACC;
         ST_D_CMP:   cmd.op = kce_pkg::OP_CMP;
         ST_A_RD:    cmd.op = kce_pkg::OP_RD_SUM;
         ST_A_WR:    cmd.op = kce_pkg::OP_WR_SUM;
         ST_A_CNT:   cmd.op = kce_pkg::OP_CNT;
         ST_U_RD:    cmd.op = kce_pkg::OP_RD_UPD;
         ST_U_DIV:   cmd.op = kce_pkg::OP_DIV;
         ST_U_WAIT:  cmd.op = kce_pkg::OP_NONE;
         ST_U_WR:    cmd.op = kce_pkg::OP_WR_UPD;
         ST_U_END:   cmd.op = kce_pkg::OP_NONE;
         ST_E_RD:    cmd.op = kce_pkg::OP_RD_CEN;
         ST_E_OUT: begin
            if (!status.out_busy) cmd.op = kce_pkg::OP_EMIT;
         end
         default:    cmd.op = kce_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         dim_cfg_ff  <= kce_pkg::CFG_DIM_W'(2);
         k_cfg_ff    <= kce_pkg::CFG_K_W'(2);
         n_cfg_ff    <= kce_pkg::CFG_N_W'(1);
         iter_cfg_ff <= kce_pkg::CFG_IT_W'(200);
         lp_ff       <= '0;
         base_ff     <= '0;
         i_ff        <= '0;
         c_ff        <= '0;
         j_ff        <= '0;
         iter_ff     <= '0;
         conv_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               kce_pkg::CSR_DIM:  dim_cfg_ff  <= csr_wdata[kce_pkg::CFG_DIM_W-1:0];
               kce_pkg::CSR_K:    k_cfg_ff    <= csr_wdata[kce_pkg::CFG_K_W-1:0];
               kce_pkg::CSR_N:    n_cfg_ff    <= csr_wdata[kce_pkg::CFG_N_W-1:0];
               kce_pkg::CSR_ITER: iter_cfg_ff <= csr_wdata[kce_pkg::CFG_IT_W-1:0];
               default: begin
               end
            endcase
         end
         unique case (state_ff)
            ST_LOAD: begin
               if (req_valid) begin
                  if (kce_pkg::TOTW'(lp_ff) + 1'b1 >= total) begin
                     lp_ff    <= '0;
                     base_ff  <= '0;
                     c_ff     <= '0;
                     j_ff     <= '0;
                     state_ff <= ST_SEED_RD;
                  end else begin
                     lp_ff <= lp_ff + 1'b1;
                  end
               end
            end
            ST_SEED_RD: state_ff <= ST_SEED_WR;
            ST_SEED_WR: begin
               if (j_last) begin
                  j_ff    <= '0;
                  base_ff <= base_ff + kce_pkg::OAW'(dim);
                  if (c_last) begin
                     c_ff     <= '0;
                     iter_ff  <= '0;
                     conv_ff  <= 1'b0;
                     state_ff <= (iter_cfg_ff == '0) ? ST_E_RD : ST_PASS;
                  end else begin
                     c_ff     <= c_ff + 1'b1;
                     state_ff <= ST_SEED_RD;
                  end
               end else begin
                  j_ff     <= j_ff + 1'b1;
                  state_ff <= ST_SEED_RD;
               end
            end
            ST_PASS: begin
               i_ff     <= '0;
               base_ff  <= '0;
               c_ff     <= '0;
               j_ff     <= '0;
               state_ff <= ST_D_RD;
            end
            ST_D_RD:   state_ff <= ST_D_DIFF;
            ST_D_DIFF: state_ff <= ST_D_MUL;
            ST_D_MUL:  state_ff <= ST_D_ACC;
            ST_D_ACC: begin
               if (j_last) begin
                  j_ff     <= '0;
                  state_ff <= ST_D_CMP;
               end else begin
                  j_ff     <= j_ff + 1'b1;
                  state_ff <= ST_D_RD;
               end
            end
            ST_D_CMP: begin
               if (c_last) begin
                  c_ff     <= '0;
                  state_ff <= ST_A_RD;
               end else begin
                  c_ff     <= c_ff + 1'b1;
                  state_ff <= ST_D_RD;
               end
            end
            ST_A_RD: state_ff <= ST_A_WR;
            ST_A_WR: begin
               if (j_last) begin
                  j_ff     <= '0;
                  state_ff <= ST_A_CNT;
               end else begin
                  j_ff     <= j_ff + 1'b1;
                  state_ff <= ST_A_RD;
               end
            end
            ST_A_CNT: begin
               if (i_last) begin
                  c_ff     <= '0;
                  j_ff     <= '0;
                  state_ff <= ST_U_RD;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  base_ff  <= base_ff + kce_pkg::OAW'(dim);
                  state_ff <= ST_D_RD;
               end
            end
            ST_U_RD:  state_ff <= ST_U_DIV;
            ST_U_DIV: state_ff <= ST_U_WAIT;
            ST_U_WAIT: begin
               if (status.div_done) state_ff <= ST_U_WR;
            end
            ST_U_WR: begin
               if (j_last) begin
                  j_ff <= '0;
                  if (c_last) begin
                     c_ff     <= '0;
                     state_ff <= ST_U_END;
                  end else begin
                     c_ff     <= c_ff + 1'b1;
                     state_ff <= ST_U_RD;
                  end
               end else begin
                  j_ff     <= j_ff + 1'b1;
                  state_ff <= ST_U_RD;
               end
            end
            ST_U_END: begin
               if (status.same) begin
                  conv_ff  <= 1'b1;
                  state_ff <= ST_E_RD;
               end else if (it_last) begin
                  conv_ff  <= 1'b0;
                  state_ff <= ST_E_RD;
               end else begin
                  iter_ff  <= iter_ff + 1'b1;
                  state_ff <= ST_PASS;
               end
            end
            ST_E_RD: state_ff <= ST_E_OUT;
            ST_E_OUT: begin
               if (!status.out_busy) begin
                  if (j_last) begin
                     j_ff <= '0;
                     if (c_last) begin
                        c_ff     <= '0;
                        state_ff <= ST_LOAD;
                     end else begin
                        c_ff     <= c_ff + 1'b1;
                        state_ff <= ST_E_RD;
                     end
                  end else begin
                     j_ff     <= j_ff + 1'b1;
                     state_ff <= ST_E_RD;
                  end
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

   a_emit_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == kce_pkg::OP_EMIT |-> !status.out_busy)
      else $error("result word overwritten before taken");
   a_update_after_divide: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_U_WR |-> $past(status.div_done))
      else $error("mean written before divider finished");
   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> cmd.op == kce_pkg::OP_LOAD)
      else $error("accepted coordinate not stored");
endmodule
`default_nettype wire

/* design/kmeans_clustering_engine.sv */
// channel   dir  handshake          payload
// req_bus   in   valid/ready        coordinate_value, observation-major
// rsp_bus   out  valid/ready        centroid_value, cluster_index, coordinate_index,
//                                   converged, last_of_run (cluster-major)
// csr_*     in   csr_we, no wait    csr_index, csr_wdata
//
// loading stores each accepted word; the last word of a run starts clustering
// seeding fills each centroid from an observation or with zero; a pass assigns
// every observation, then updates the means, its length set by the single
// squared-difference unit and the bit-serial divider
// reset is synchronous, active high; the stores need no clearing pass
// words are not taken while a run is clustering or emitting; a stalled result
// holds in the output register
`timescale 1ns / 1ps
`default_nettype none
module kmeans_clustering_engine (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [kce_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [kce_pkg::CSR_W-1:0]       csr_wdata,
   kce_req_if.sink                              req_bus,
   kce_rsp_if.source                            rsp_bus
);
   kce_pkg::kce_cmd_type    cmd;
   kce_pkg::kce_status_type status;

   kce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   kce_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .load_value           (req_bus.coordinate_value),
      .status               (status),
      .rsp_ready            (rsp_bus.ready),
      .rsp_valid            (rsp_bus.valid),
      .rsp_centroid_value   (rsp_bus.centroid_value),
      .rsp_cluster_index    (rsp_bus.cluster_index),
      .rsp_coordinate_index (rsp_bus.coordinate_index),
      .rsp_converged        (rsp_bus.converged),
      .rsp_last_of_run      (rsp_bus.last_of_run)
   );
endmodule
`default_nettype wire
